/* rtl/core/rdmc_pkg.sv */
`default_nettype none

package rdmc_pkg;

   // request kinds carried on req_tuser
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_STEP  = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // result kinds carried on rsp_tuser
   localparam logic [2:0] STAT_CARVED   = 3'd0;
   localparam logic [2:0] STAT_BACKTRACK = 3'd1;
   localparam logic [2:0] STAT_FINISHED = 3'd2;
   localparam logic [2:0] STAT_STARTED  = 3'd3;
   localparam logic [2:0] STAT_READ     = 3'd4;

   // carve directions
   localparam logic [1:0] DIR_LEFT  = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_UP    = 2'd2;
   localparam logic [1:0] DIR_DOWN  = 2'd3;

   // opening bits of a cell entry
   localparam logic [3:0] OPEN_LEFT   = 4'b0001;
   localparam logic [3:0] OPEN_RIGHT  = 4'b0010;
   localparam logic [3:0] OPEN_TOP    = 4'b0100;
   localparam logic [3:0] OPEN_BOTTOM = 4'b1000;

   // cell entry: {visited, openings[3:0]}
   localparam int CELL_W  = 5;
   localparam int VIS_BIT = 4;

   // configuration register indexes and reset values
   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;
   localparam logic [5:0] GRID_WIDTH_RESET  = 6'd20;
   localparam logic [4:0] GRID_HEIGHT_RESET = 5'd15;

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_FETCH  = 9'b000000100,
      ST_CUR    = 9'b000001000,
      ST_SCAN   = 9'b000010000,
      ST_DECIDE = 9'b000100000,
      ST_WRNXT  = 9'b001000000,
      ST_RDCELL = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   // result payload, last field in the lowest bits
   typedef struct packed {
      logic [9:0] path_depth;
      logic [3:0] openings;
      logic [1:0] move_dir;
      logic [3:0] cell_row;
      logic [4:0] cell_col;
   } rsp_data_type;

   // wall bit on the cell we carve from
   function automatic logic [3:0] here_bit(input logic [1:0] dir);
      logic [3:0] bits;
      case (dir)
         DIR_LEFT:  bits = OPEN_LEFT;
         DIR_RIGHT: bits = OPEN_RIGHT;
         DIR_UP:    bits = OPEN_TOP;
         default:   bits = OPEN_BOTTOM;
      endcase
      return bits;
   endfunction

   // wall bit on the cell we carve into
   function automatic logic [3:0] there_bit(input logic [1:0] dir);
      logic [3:0] bits;
      case (dir)
         DIR_LEFT:  bits = OPEN_RIGHT;
         DIR_RIGHT: bits = OPEN_LEFT;
         DIR_UP:    bits = OPEN_BOTTOM;
         default:   bits = OPEN_TOP;
      endcase
      return bits;
   endfunction

   // 16-bit value modulo 3: 4 is 1 mod 3, so fold base-4 digits
   function automatic logic [1:0] mod3_16(input logic [15:0] v);
      logic [4:0] s;
      logic [2:0] t;
      logic [2:0] u;
      s = 5'd0;
      for (int i = 0; i < 8; i++) begin
         s = s + 5'(v[2*i +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      u = 3'(t[1:0]) + 3'(t[2]);
      if (u >= 3'd3) begin
         u = u - 3'd3;
      end
      return u[1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/random_dfs_maze_carver_unit.sv */
`default_nettype none

// Channel   Dir  Handshake            Payload
// req_      in   tvalid/tready        tuser: func; tdata: random_value, read_col, read_row
// rsp_      out  tvalid/tready        tuser: status; tdata: cell_col .. path_depth
// csr_      in   we (no wait)         addr: register index; wdata: value
//
// A start sweeps the whole cell memory clear; a carving step reads the stack, the
// current cell and its four neighbors, then writes two cells; a backtracking step
// makes the same reads and no write; a step on an empty stack touches no memory; a
// read reads one cell. After reset all MAX_COLS*MAX_ROWS cell entries (512 at the
// defaults) are cleared before req_tready rises. A result waits in the output register
// while the next transaction is taken; the block stalls only when that register is full.
module random_dfs_maze_carver_unit #(
   parameter int MAX_COLS = 32,
   parameter int MAX_ROWS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // func
   input  logic [31:0] req_tdata,   // random_value[15:0], read_col[20:16], read_row[24:21]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // status
   output logic [31:0] rsp_tdata,   // cell_col[4:0], cell_row[8:5], move_dir[10:9],
                                    // openings[14:11], path_depth[24:15]
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [5:0]  csr_wdata
);
   import rdmc_pkg::*;

   localparam int CELLS = MAX_COLS * MAX_ROWS;
   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int IDX_W = $clog2(CELLS);
   localparam int SP_W  = $clog2(CELLS + 1);
   localparam int WD_W  = $clog2(MAX_COLS + 1);
   localparam int HT_W  = $clog2(MAX_ROWS + 1);
   localparam int STK_W = ROW_W + COL_W;

   // configuration
   logic [5:0] grid_width_ff;
   logic [4:0] grid_height_ff;

   // control
   state_type       state_ff, state_in;
   logic [IDX_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic            clr_start_ff, clr_start_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [1:0]      scan_ff, scan_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // payload
   logic [15:0]       rnd_ff, rnd_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [3:0]        cur_open_ff, cur_open_in;
   logic [CELL_W-1:0] nbr_ff [4];
   logic [CELL_W-1:0] nbr_in [4];
   logic [1:0]        dir_ff, dir_in;
   logic [2:0]        res_status_ff, res_status_in;
   rsp_data_type      res_ff, res_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   rsp_data_type      rsp_ff, rsp_in;

   // memory ports
   logic              cell_we;
   logic [IDX_W-1:0]  cell_waddr, cell_raddr;
   logic [CELL_W-1:0] cell_wdata, cell_rdata;
   logic              stk_we;
   logic [IDX_W-1:0]  stk_waddr, stk_raddr;
   logic [STK_W-1:0]  stk_wdata, stk_rdata;

   // derived values
   logic [WD_W-1:0]  w_clamp;
   logic [HT_W-1:0]  h_clamp;
   logic [IDX_W-1:0] cur_idx, fetch_idx, read_idx;
   logic [IDX_W-1:0] nbr_addr [4];
   logic [3:0]       cand_ok, free_mask;
   logic [2:0]       free_cnt;
   logic [1:0]       pick_k, sel_dir;
   logic             carve;
   logic             read_inside;
   logic [COL_W-1:0] nxt_col;
   logic [ROW_W-1:0] nxt_row;
   logic [3:0]       nxt_open;
   logic             req_accept;
   logic [15:0]      req_rnd;
   logic [4:0]       req_col;
   logic [3:0]       req_row;

   function automatic logic [IDX_W-1:0] cell_idx(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
      return IDX_W'(32'(r) * MAX_COLS + 32'(c));
   endfunction

   rdmc_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_waddr),
      .wr_data (cell_wdata),
      .rd_addr (cell_raddr),
      .rd_data (cell_rdata)
   );

   rdmc_ram #(.WIDTH(STK_W), .DEPTH(CELLS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign req_accept = req_tvalid && req_tready;
   assign req_rnd    = req_tdata[15:0];
   assign req_col    = req_tdata[20:16];
   assign req_row    = req_tdata[24:21];

   // grid size: zero acts as one, above the storage acts as the storage
   always_comb begin
      if (grid_width_ff == 6'd0) begin
         w_clamp = WD_W'(1);
      end else if (32'(grid_width_ff) > MAX_COLS) begin
         w_clamp = WD_W'(MAX_COLS);
      end else begin
         w_clamp = WD_W'(grid_width_ff);
      end
      if (grid_height_ff == 5'd0) begin
         h_clamp = HT_W'(1);
      end else if (32'(grid_height_ff) > MAX_ROWS) begin
         h_clamp = HT_W'(MAX_ROWS);
      end else begin
         h_clamp = HT_W'(grid_height_ff);
      end
   end

   assign cur_idx     = cell_idx(cur_row_ff, cur_col_ff);
   assign fetch_idx   = cell_idx(stk_rdata[STK_W-1:COL_W], stk_rdata[COL_W-1:0]);
   assign read_idx    = cell_idx(ROW_W'(req_row), COL_W'(req_col));
   assign read_inside = (32'(req_col) < MAX_COLS) && (32'(req_row) < MAX_ROWS);

   // neighbors inside the current grid, in the order left, right, up, down
   always_comb begin
      logic [31:0] xi, yi, wi, hi;
      xi = 32'(cur_col_ff);
      yi = 32'(cur_row_ff);
      wi = 32'(w_clamp);
      hi = 32'(h_clamp);
      cand_ok[DIR_LEFT]  = (xi != 0) && (xi <= wi) && (yi < hi);
      cand_ok[DIR_RIGHT] = (xi + 1 < wi) && (yi < hi);
      cand_ok[DIR_UP]    = (yi != 0) && (yi <= hi) && (xi < wi);
      cand_ok[DIR_DOWN]  = (yi + 1 < hi) && (xi < wi);
   end

   // neighbor addresses; a neighbor off the grid reads the current cell
   always_comb begin
      nbr_addr[DIR_LEFT]  = cand_ok[DIR_LEFT]  ? cur_idx - IDX_W'(1) : cur_idx;
      nbr_addr[DIR_RIGHT] = cand_ok[DIR_RIGHT] ? cur_idx + IDX_W'(1) : cur_idx;
      nbr_addr[DIR_UP]    = cand_ok[DIR_UP]    ? cur_idx - IDX_W'(MAX_COLS) : cur_idx;
      nbr_addr[DIR_DOWN]  = cand_ok[DIR_DOWN]  ? cur_idx + IDX_W'(MAX_COLS) : cur_idx;
   end

   // choose among the free neighbors
   always_comb begin
      logic [1:0] seen;
      for (int d = 0; d < 4; d++) begin
         free_mask[d] = cand_ok[d] && !nbr_ff[d][VIS_BIT];
      end
      free_cnt = 3'($countones(free_mask));
      case (free_cnt)
         3'd2:    pick_k = {1'b0, rnd_ff[0]};
         3'd3:    pick_k = mod3_16(rnd_ff);
         3'd4:    pick_k = rnd_ff[1:0];
         default: pick_k = 2'd0;
      endcase
      sel_dir = DIR_LEFT;
      seen    = 2'd0;
      for (int d = 0; d < 4; d++) begin
         if (free_mask[d]) begin
            if (seen == pick_k) begin
               sel_dir = 2'(d);
            end
            seen = seen + 2'd1;
         end
      end
      carve = (free_cnt != 3'd0) && (32'(sp_ff) < CELLS);
   end

   // cell entered by the chosen carve
   always_comb begin
      nxt_col = cur_col_ff;
      nxt_row = cur_row_ff;
      case (dir_ff)
         DIR_LEFT:  nxt_col = cur_col_ff - COL_W'(1);
         DIR_RIGHT: nxt_col = cur_col_ff + COL_W'(1);
         DIR_UP:    nxt_row = cur_row_ff - ROW_W'(1);
         DIR_DOWN:  nxt_row = cur_row_ff + ROW_W'(1);
         default:   nxt_col = cur_col_ff;
      endcase
      nxt_open = nbr_ff[dir_ff][3:0] | there_bit(dir_ff);
   end

   assign req_tready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_start_in  = clr_start_ff;
      sp_in         = sp_ff;
      scan_in       = scan_ff;
      rnd_in        = rnd_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      cur_open_in   = cur_open_ff;
      nbr_in        = nbr_ff;
      dir_in        = dir_ff;
      res_status_in = res_status_ff;
      res_in        = res_ff;
      rsp_status_in = rsp_status_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;

      cell_we    = 1'b0;
      cell_waddr = clr_cnt_ff;
      cell_wdata = '0;
      cell_raddr = cur_idx;
      stk_we     = 1'b0;
      stk_waddr  = IDX_W'(sp_ff);
      stk_wdata  = {nxt_row, nxt_col};
      stk_raddr  = IDX_W'(sp_ff - SP_W'(1));

      // output register drains on its own handshake
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            cell_we    = 1'b1;
            cell_waddr = clr_cnt_ff;
            if (clr_start_ff && clr_cnt_ff == '0) begin
               cell_wdata = CELL_W'(1 << VIS_BIT);
            end
            if (clr_cnt_ff == IDX_W'(CELLS - 1)) begin
               clr_start_in = 1'b0;
               if (clr_start_ff) begin
                  sp_in    = SP_W'(1);
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               clr_cnt_in = clr_cnt_ff + IDX_W'(1);
            end
         end

         ST_IDLE: begin
            if (req_accept) begin
               rnd_in = req_rnd;
               res_in = '0;
               case (req_tuser)
                  FUNC_START: begin
                     // path starts at cell (0,0)
                     stk_we             = 1'b1;
                     stk_waddr          = '0;
                     stk_wdata          = '0;
                     clr_cnt_in         = '0;
                     clr_start_in       = 1'b1;
                     res_status_in      = STAT_STARTED;
                     res_in.path_depth  = 10'd1;
                     state_in           = ST_CLEAR;
                  end
                  FUNC_STEP: begin
                     if (sp_ff == '0) begin
                        res_status_in = STAT_FINISHED;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
                  FUNC_READ: begin
                     res_status_in     = STAT_READ;
                     res_in.cell_col   = req_col;
                     res_in.cell_row   = req_row;
                     res_in.path_depth = 10'(sp_ff);
                     if (read_inside) begin
                        cell_raddr = read_idx;
                        state_in   = ST_RDCELL;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_FETCH: begin
            cur_col_in = stk_rdata[COL_W-1:0];
            cur_row_in = stk_rdata[STK_W-1:COL_W];
            cell_raddr = fetch_idx;
            state_in   = ST_CUR;
         end

         ST_CUR: begin
            cur_open_in = cell_rdata[3:0];
            cell_raddr  = nbr_addr[0];
            scan_in     = 2'd0;
            state_in    = ST_SCAN;
         end

         ST_SCAN: begin
            nbr_in[scan_ff] = cell_rdata;
            if (scan_ff == 2'd3) begin
               state_in = ST_DECIDE;
            end else begin
               cell_raddr = nbr_addr[scan_ff + 2'd1];
               scan_in    = scan_ff + 2'd1;
            end
         end

         ST_DECIDE: begin
            if (carve) begin
               cell_we    = 1'b1;
               cell_waddr = cur_idx;
               cell_wdata = {1'b1, cur_open_ff | here_bit(sel_dir)};
               dir_in     = sel_dir;
               state_in   = ST_WRNXT;
            end else begin
               // dead end: pop
               sp_in             = sp_ff - SP_W'(1);
               res_status_in     = STAT_BACKTRACK;
               res_in.cell_col   = 5'(cur_col_ff);
               res_in.cell_row   = 4'(cur_row_ff);
               res_in.move_dir   = DIR_LEFT;
               res_in.openings   = cur_open_ff;
               res_in.path_depth = 10'(sp_ff - SP_W'(1));
               state_in          = ST_DONE;
            end
         end

         ST_WRNXT: begin
            cell_we           = 1'b1;
            cell_waddr        = nbr_addr[dir_ff];
            cell_wdata        = {1'b1, nxt_open};
            stk_we            = 1'b1;
            stk_waddr         = IDX_W'(sp_ff);
            stk_wdata         = {nxt_row, nxt_col};
            sp_in             = sp_ff + SP_W'(1);
            res_status_in     = STAT_CARVED;
            res_in.cell_col   = 5'(nxt_col);
            res_in.cell_row   = 4'(nxt_row);
            res_in.move_dir   = dir_ff;
            res_in.openings   = nxt_open;
            res_in.path_depth = 10'(sp_ff + SP_W'(1));
            state_in          = ST_DONE;
         end

         ST_RDCELL: begin
            res_in.openings = cell_rdata[3:0];
            state_in        = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_status_in = res_status_ff;
               rsp_in        = res_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_cnt_ff     <= '0;
         clr_start_ff   <= 1'b0;
         sp_ff          <= '0;
         scan_ff        <= 2'd0;
         rsp_valid_ff   <= 1'b0;
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_start_ff <= clr_start_in;
         sp_ff        <= sp_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata;
               CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata[4:0];
               default:         grid_width_ff  <= grid_width_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rnd_ff        <= rnd_in;
      cur_col_ff    <= cur_col_in;
      cur_row_ff    <= cur_row_in;
      cur_open_ff   <= cur_open_in;
      nbr_ff        <= nbr_in;
      dir_ff        <= dir_in;
      res_status_ff <= res_status_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, rsp_ff};

`ifndef SYNTH
   // the path never holds more cells than the grid storage
   assert property (@(posedge clock) disable iff (reset) 32'(sp_ff) <= CELLS)
      else $error("path depth beyond cell count");

   // a carve only enters a cell that was read as unvisited
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRNXT) |-> !nbr_ff[dir_ff][VIS_BIT])
      else $error("carve into a visited cell");

   // a carved cell reports the wall back toward its parent as open
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STAT_CARVED) |->
         ((rsp_ff.openings & there_bit(rsp_ff.move_dir)) != 4'd0))
      else $error("carved cell misses its back opening");

   // a start leaves exactly one cell on the path
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && clr_start_ff && clr_cnt_ff == IDX_W'(CELLS - 1))
         |=> (sp_ff == SP_W'(1)))
      else $error("start did not leave one cell on the path");
`endif

endmodule

`default_nettype wire

/* rtl/core/rdmc_ram.sv */
`default_nettype none

module rdmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import rdmc_pkg::*;

   // function code the block ignores
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   // move_dir reads as zero when nothing is carved
   localparam logic [1:0] NO_MOVE = DIR_LEFT;

   localparam int GRID_COLS     = 32;
   localparam int GRID_ROWS     = 16;
   localparam int CELL_TOTAL    = GRID_COLS * GRID_ROWS;
   localparam int SETTLE_CYCLES = 600;    // longer than a start with its clearing sweep
   localparam int STALL_LIMIT   = 8000;
   localparam int RANDOM_ITEMS  = 680;
   localparam int MAX_REPORTS   = 10;

   typedef struct {
      logic [2:0]   status;
      rsp_data_type payload;
   } carve_result_type;

   // maze state mirror plus the queue of results still owed by the block
   class maze_scoreboard;
      logic [5:0]       width_reg;
      logic [4:0]       height_reg;
      bit               visited [CELL_TOTAL];
      logic [3:0]       walls [CELL_TOTAL];
      int               path [CELL_TOTAL];
      int unsigned      depth;
      carve_result_type expected_q [$];
      int               errors;

      function new();
         width_reg  = GRID_WIDTH_RESET;
         height_reg = GRID_HEIGHT_RESET;
         depth      = 0;
         errors     = 0;
         clear_maze();
      endfunction

      function void clear_maze();
         for (int i = 0; i < CELL_TOTAL; i++) begin
            visited[i] = 1'b0;
            walls[i]   = 4'd0;
         end
      endfunction

      function void write_reg(logic idx, logic [5:0] value);
         if (idx == CSR_GRID_WIDTH) begin
            width_reg = value;
         end else begin
            height_reg = value[4:0];
         end
      endfunction

      // zero acts as one, anything past storage acts as the maximum
      function int grid_cols();
         if (width_reg == 0) return 1;
         return (width_reg > GRID_COLS) ? GRID_COLS : int'(width_reg);
      endfunction

      function int grid_rows();
         if (height_reg == 0) return 1;
         return (height_reg > GRID_ROWS) ? GRID_ROWS : int'(height_reg);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void push_result(logic [2:0] status, int col, int row, logic [1:0] dir,
                                logic [3:0] open);
         carve_result_type r;
         r.status             = status;
         r.payload.cell_col   = col[4:0];
         r.payload.cell_row   = row[3:0];
         r.payload.move_dir   = dir;
         r.payload.openings   = open;
         r.payload.path_depth = depth[9:0];
         expected_q.insert(expected_q.size(), r);
      endfunction

      // advance the mirror by one accepted request transaction
      function void note_request(logic [1:0] func, logic [15:0] rnd, logic [4:0] col,
                                 logic [3:0] row);
         int         w;
         int         h;
         int         cur;
         int         x;
         int         y;
         int         n;
         int         k;
         int         nxt;
         int         cand [4];
         logic [1:0] dirs [4];
         logic [3:0] here_mask;
         logic [3:0] there_mask;
         w = grid_cols();
         h = grid_rows();
         case (func)
            FUNC_START: begin
               clear_maze();
               visited[0] = 1'b1;
               path[0]    = 0;
               depth      = 1;
               push_result(STAT_STARTED, 0, 0, NO_MOVE, 4'd0);
            end
            FUNC_READ: begin
               push_result(STAT_READ, int'(col), int'(row), NO_MOVE,
                           walls[int'(row) * GRID_COLS + int'(col)]);
            end
            FUNC_STEP: begin
               if (depth == 0 || depth > CELL_TOTAL) begin
                  // nothing left on the path: maze is finished
                  depth = 0;
                  push_result(STAT_FINISHED, 0, 0, NO_MOVE, 4'd0);
               end else begin
                  cur = path[depth - 1] % CELL_TOTAL;
                  x   = cur % GRID_COLS;
                  y   = cur / GRID_COLS;
                  n   = 0;
                  // free neighbors in the grid as it is sized now
                  if (x > 0 && x - 1 < w && y < h && !visited[cur - 1]) begin
                     cand[n] = cur - 1;
                     dirs[n] = DIR_LEFT;
                     n++;
                  end
                  if (x + 1 < w && y < h && !visited[cur + 1]) begin
                     cand[n] = cur + 1;
                     dirs[n] = DIR_RIGHT;
                     n++;
                  end
                  if (y > 0 && y - 1 < h && x < w && !visited[cur - GRID_COLS]) begin
                     cand[n] = cur - GRID_COLS;
                     dirs[n] = DIR_UP;
                     n++;
                  end
                  if (y + 1 < h && x < w && !visited[cur + GRID_COLS]) begin
                     cand[n] = cur + GRID_COLS;
                     dirs[n] = DIR_DOWN;
                     n++;
                  end
                  if (n > 0 && depth < CELL_TOTAL) begin
                     k   = int'(rnd) % n;
                     nxt = cand[k];
                     case (dirs[k])
                        DIR_LEFT: begin
                           here_mask  = OPEN_LEFT;
                           there_mask = OPEN_RIGHT;
                        end
                        DIR_RIGHT: begin
                           here_mask  = OPEN_RIGHT;
                           there_mask = OPEN_LEFT;
                        end
                        DIR_UP: begin
                           here_mask  = OPEN_TOP;
                           there_mask = OPEN_BOTTOM;
                        end
                        default: begin
                           here_mask  = OPEN_BOTTOM;
                           there_mask = OPEN_TOP;
                        end
                     endcase
                     walls[cur]   = walls[cur] | here_mask;
                     walls[nxt]   = walls[nxt] | there_mask;
                     visited[nxt] = 1'b1;
                     path[depth]  = nxt;
                     depth++;
                     push_result(STAT_CARVED, nxt % GRID_COLS, nxt / GRID_COLS, dirs[k],
                                 walls[nxt]);
                  end else begin
                     depth--;
                     push_result(STAT_BACKTRACK, x, y, NO_MOVE, walls[cur]);
                  end
               end
            end
            default: ;  // unused code: no result
         endcase
      endfunction

      // compare one result transaction against the oldest expectation
      function void check_result(logic [2:0] status, rsp_data_type got);
         carve_result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("unexpected result: status %0d col %0d row %0d dir %0d open %h depth %0d",
                        status, got.cell_col, got.cell_row, got.move_dir, got.openings,
                        got.path_depth);
            end
            return;
         end
         want = expected_q.pop_front();
         if (want.status !== status
             || want.payload.cell_col !== got.cell_col
             || want.payload.cell_row !== got.cell_row
             || want.payload.move_dir !== got.move_dir
             || want.payload.openings !== got.openings
             || want.payload.path_depth !== got.path_depth) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("mismatch: expected status %0d col %0d row %0d dir %0d open %h depth %0d",
                        want.status, want.payload.cell_col, want.payload.cell_row,
                        want.payload.move_dir, want.payload.openings,
                        want.payload.path_depth);
               $display("          got      status %0d col %0d row %0d dir %0d open %h depth %0d",
                        status, got.cell_col, got.cell_row, got.move_dir, got.openings,
                        got.path_depth);
            end
         end
      endfunction

      function void check_drained();
         if (expected_q.size() != 0) begin
            errors += expected_q.size();
            $display("%0d expected results never arrived", expected_q.size());
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser  = FUNC_START;   // func
   logic [31:0] req_tdata  = 32'd0;        // random_value, read_col, read_row
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [2:0]  rsp_tuser;                 // status
   logic [31:0] rsp_tdata;                 // cell_col, cell_row, move_dir, openings, path_depth
   logic        csr_we     = 1'b0;
   logic        csr_addr   = CSR_GRID_WIDTH;
   logic [5:0]  csr_wdata  = 6'd0;

   logic        no_idle    = 1'b0;
   int          items_sent = 0;
   int          stall_cycles = 0;

   maze_scoreboard sb = new();

   random_dfs_maze_carver_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random back-pressure and checking
   always @(posedge clock) begin
      rsp_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 32);
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tuser, rsp_data_type'(rsp_tdata[24:0]));
      end
   end

   // watchdog: too long without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // one request transaction, with a random gap in front of it
   task automatic send_item(logic [1:0] func, logic [15:0] rnd, logic [4:0] col,
                            logic [3:0] row);
      if (!no_idle) begin
         while ($urandom_range(99) < 32) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {7'd0, row, col, rnd};
      do @(posedge clock); while (!req_tready);
      sb.note_request(func, rnd, col, row);
      if (func != FUNC_UNUSED) items_sent++;
   endtask

   // hold off until every result is in and the block has gone quiet
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_grid(logic [5:0] wval, logic [5:0] hval);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_GRID_WIDTH;
      csr_wdata <= wval;
      sb.write_reg(CSR_GRID_WIDTH, wval);
      @(posedge clock);
      csr_addr  <= CSR_GRID_HEIGHT;
      csr_wdata <= hval;
      sb.write_reg(CSR_GRID_HEIGHT, hval);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // resize, optionally start over, then a mostly-step random mix
   task automatic run_phase(logic [5:0] wval, logic [5:0] hval, bit fresh, int count);
      int         pick;
      logic [4:0] col;
      logic [3:0] row;
      drain_results();
      set_grid(wval, hval);
      if (fresh) begin
         send_item(FUNC_START, 16'($urandom), 5'($urandom), 4'($urandom));
      end
      repeat (count) begin
         pick = $urandom_range(99);
         col  = 5'($urandom_range(31));
         row  = 4'($urandom_range(15));
         if (pick < 2) begin
            send_item(FUNC_START, 16'($urandom), col, row);
         end else if (pick < 4) begin
            send_item(FUNC_UNUSED, 16'($urandom), col, row);
         end else if (pick < 16) begin
            // half the reads are placed inside the grid in use
            if ($urandom_range(1) == 1) begin
               col = 5'($urandom_range(sb.grid_cols() - 1));
               row = 4'($urandom_range(sb.grid_rows() - 1));
            end
            send_item(FUNC_READ, 16'($urandom), col, row);
         end else begin
            send_item(FUNC_STEP, 16'($urandom_range(65535)), col, row);
         end
      end
   endtask

   initial begin
      int w;
      int h;
      int random_goal;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset grid, empty stack, extremes of the fields
      send_item(FUNC_STEP, 16'h0000, 5'd0, 4'd0);
      send_item(FUNC_READ, 16'hFFFF, 5'd0, 4'd0);
      send_item(FUNC_READ, 16'h0000, 5'd31, 4'd15);
      send_item(FUNC_UNUSED, 16'hFFFF, 5'd31, 4'd15);
      send_item(FUNC_START, 16'h0000, 5'd0, 4'd0);
      send_item(FUNC_STEP, 16'h0000, 5'd31, 4'd15);
      send_item(FUNC_STEP, 16'hFFFF, 5'd0, 4'd0);
      send_item(FUNC_STEP, 16'h0001, 5'd0, 4'd0);
      send_item(FUNC_STEP, 16'h0002, 5'd0, 4'd0);
      send_item(FUNC_READ, 16'h0000, 5'd0, 4'd0);
      // restart in the middle of a search
      send_item(FUNC_START, 16'hFFFF, 5'd31, 4'd15);
      send_item(FUNC_READ, 16'h0000, 5'd1, 4'd0);

      // 2x2 grid: carve it out, unwind, then finished twice
      drain_results();
      set_grid(6'd2, 6'd2);
      send_item(FUNC_START, 16'h0000, 5'd0, 4'd0);
      repeat (9) send_item(FUNC_STEP, 16'($urandom), 5'd0, 4'd0);
      send_item(FUNC_READ, 16'h0000, 5'd1, 4'd1);
      send_item(FUNC_READ, 16'h0000, 5'd5, 4'd5);

      // random: fixed settings at the extremes first
      random_goal = items_sent + RANDOM_ITEMS;
      run_phase(6'd3, 6'd2, 1'b1, 20);
      run_phase(6'd0, 6'd0, 1'b1, 8);
      run_phase(6'd1, 6'd5, 1'b1, 16);
      run_phase(6'd63, 6'd17, 1'b1, 150);
      // shrink during the search, path continues
      run_phase(6'd5, 6'd4, 1'b0, 60);
      no_idle <= 1'b1;
      run_phase(6'd32, 6'd1, 1'b1, 70);
      run_phase(6'd2, 6'd16, 1'b1, 70);
      no_idle <= 1'b0;
      // grow back during the search
      run_phase(6'd33, 6'd31, 1'b0, 60);

      // then small random grids until the budget is used
      while (items_sent < random_goal) begin
         w = $urandom_range(8, 2);
         h = $urandom_range(6, 2);
         run_phase(6'(w), {1'($urandom_range(1)), 5'(h)}, $urandom_range(99) < 80,
                   2 * w * h + $urandom_range(12, 4));
      end

      drain_results();
      sb.check_drained();
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
